// ===== design/tbpd_pkg.sv =====
// ----------------------------------------------------------------------------
// tbpd_pkg
// Shared types and constants of the text/bitmap pixel decoder: field widths,
// register map, mode bits and the structs passed between the modules.
// ----------------------------------------------------------------------------
package tbpd_pkg;

  // field widths
  localparam int unsigned GfxW   = 8;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned ColorW = 4;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned NumPix = 8;
  localparam int unsigned PixW   = NumPix * ColorW;

  // configuration port
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned RegIdxW = 3;

  // register map, index = paddr / 4
  typedef enum logic [RegIdxW-1:0] {
    REG_DISPLAY_MODE = 3'd0,
    REG_BG_COLOR0    = 3'd1,
    REG_BG_COLOR1    = 3'd2,
    REG_BG_COLOR2    = 3'd3,
    REG_BG_COLOR3    = 3'd4
  } cfg_reg_e;

  // bit positions inside display_mode
  localparam int unsigned ModeMcmBit = 0;
  localparam int unsigned ModeBmmBit = 1;
  localparam int unsigned ModeEcmBit = 2;

  // reset values of the registers
  localparam logic [ModeW-1:0]  ModeRst = 3'd0;
  localparam logic [ColorW-1:0] Bg0Rst  = 4'd6;
  localparam logic [ColorW-1:0] Bg1Rst  = 4'd1;
  localparam logic [ColorW-1:0] Bg2Rst  = 4'd2;
  localparam logic [ColorW-1:0] Bg3Rst  = 4'd3;

  localparam logic [ColorW-1:0] ColorBlack = 4'd0;

  // register file contents
  typedef struct packed {
    logic [ModeW-1:0]  display_mode;
    logic [ColorW-1:0] bg_color0;
    logic [ColorW-1:0] bg_color1;
    logic [ColorW-1:0] bg_color2;
    logic [ColorW-1:0] bg_color3;
  } cfg_t;

  // one graphics fetch
  typedef struct packed {
    logic [GfxW-1:0]   graphics_byte;
    logic [CodeW-1:0]  character_code;
    logic [ColorW-1:0] cell_color;
    logic              display_active;
  } item_t;

  // eight decoded pixels
  typedef struct packed {
    logic [PixW-1:0]   pixel_colors;
    logic [NumPix-1:0] pixel_foreground;
  } result_t;

endpackage

// ===== design/tbpd_if.sv =====
// ----------------------------------------------------------------------------
// tbpd_in_if / tbpd_out_if
// Valid/ready channels of the pixel decoder: fetch beats in, pixel beats out.
// ----------------------------------------------------------------------------
interface tbpd_in_if;
  import tbpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [GfxW-1:0]   graphics_byte;
  logic [CodeW-1:0]  character_code;
  logic [ColorW-1:0] cell_color;
  logic              display_active;

  modport source (
    output valid, graphics_byte, character_code, cell_color, display_active,
    input  ready
  );
  modport sink (
    input  valid, graphics_byte, character_code, cell_color, display_active,
    output ready
  );
endinterface

interface tbpd_out_if;
  import tbpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [PixW-1:0]   pixel_colors;
  logic [NumPix-1:0] pixel_foreground;

  modport source (
    output valid, pixel_colors, pixel_foreground,
    input  ready
  );
  modport sink (
    input  valid, pixel_colors, pixel_foreground,
    output ready
  );
endinterface

// ===== design/tbpd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tbpd_cfg_regs
// APB-style register file: display mode and four background colors.
// ----------------------------------------------------------------------------
module tbpd_cfg_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [tbpd_pkg::AddrW-1:0] paddr,
  input  logic [tbpd_pkg::DataW-1:0] pwdata,
  output logic [tbpd_pkg::DataW-1:0] prdata,
  output logic                    pready,
  output tbpd_pkg::cfg_t          cfg_o
);
  import tbpd_pkg::*;

  cfg_t           cfg_q, cfg_d;
  logic           wr_en;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_reg_e'(reg_idx))
        REG_DISPLAY_MODE: cfg_d.display_mode = pwdata[ModeW-1:0];
        REG_BG_COLOR0:    cfg_d.bg_color0    = pwdata[ColorW-1:0];
        REG_BG_COLOR1:    cfg_d.bg_color1    = pwdata[ColorW-1:0];
        REG_BG_COLOR2:    cfg_d.bg_color2    = pwdata[ColorW-1:0];
        REG_BG_COLOR3:    cfg_d.bg_color3    = pwdata[ColorW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.display_mode <= ModeRst;
      cfg_q.bg_color0    <= Bg0Rst;
      cfg_q.bg_color1    <= Bg1Rst;
      cfg_q.bg_color2    <= Bg2Rst;
      cfg_q.bg_color3    <= Bg3Rst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read-back mux
  always_comb begin
    prdata = '0;
    case (cfg_reg_e'(reg_idx))
      REG_DISPLAY_MODE: prdata = DataW'(cfg_q.display_mode);
      REG_BG_COLOR0:    prdata = DataW'(cfg_q.bg_color0);
      REG_BG_COLOR1:    prdata = DataW'(cfg_q.bg_color1);
      REG_BG_COLOR2:    prdata = DataW'(cfg_q.bg_color2);
      REG_BG_COLOR3:    prdata = DataW'(cfg_q.bg_color3);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/tbpd_decode.sv =====
// ----------------------------------------------------------------------------
// tbpd_decode
// Combinational pixel decode of one fetch for the five display modes,
// multicolor pair doubling and black output for the invalid modes.
// ----------------------------------------------------------------------------
module tbpd_decode (
  input  tbpd_pkg::item_t   item_i,
  input  tbpd_pkg::cfg_t    cfg_i,
  output tbpd_pkg::result_t result_o
);
  import tbpd_pkg::*;

  logic [CodeW-1:0]  code;
  logic [ColorW-1:0] ccol;
  logic              ecm, bmm, mcm;
  logic              multi, black;
  logic [ColorW-1:0] bgc, fgc, ecm_bg;
  logic [ColorW-1:0] pal [4];
  logic [1:0]        pair;
  logic              bit_v;
  logic [ColorW-1:0] col;

  // idle state forces code and color to zero
  assign code = item_i.display_active ? item_i.character_code : '0;
  assign ccol = item_i.display_active ? item_i.cell_color : '0;

  assign ecm   = cfg_i.display_mode[ModeEcmBit];
  assign bmm   = cfg_i.display_mode[ModeBmmBit];
  assign mcm   = cfg_i.display_mode[ModeMcmBit];
  assign multi = mcm & (bmm | ccol[ColorW-1]);
  assign black = ecm & (bmm | mcm);

  // extended-color background pick by code bits 7..6
  always_comb begin
    case (code[CodeW-1 -: 2])
      2'd0:    ecm_bg = cfg_i.bg_color0;
      2'd1:    ecm_bg = cfg_i.bg_color1;
      2'd2:    ecm_bg = cfg_i.bg_color2;
      default: ecm_bg = cfg_i.bg_color3;
    endcase
  end

  // single-bit colors and the multicolor palette
  always_comb begin
    if (bmm) begin
      bgc    = code[ColorW-1:0];
      fgc    = code[CodeW-1 -: ColorW];
      pal[0] = cfg_i.bg_color0;
      pal[1] = code[CodeW-1 -: ColorW];
      pal[2] = code[ColorW-1:0];
      pal[3] = ccol;
    end else begin
      bgc    = ecm ? ecm_bg : cfg_i.bg_color0;
      fgc    = mcm ? {1'b0, ccol[ColorW-2:0]} : ccol;
      pal[0] = cfg_i.bg_color0;
      pal[1] = cfg_i.bg_color1;
      pal[2] = cfg_i.bg_color2;
      pal[3] = {1'b0, ccol[ColorW-2:0]};
    end
  end

  // per-pixel select, bit k of the byte is pixel 7-k from the left
  always_comb begin
    result_o = '0;
    pair     = '0;
    bit_v    = 1'b0;
    col      = '0;
    for (int k = 0; k < NumPix; k++) begin
      pair  = item_i.graphics_byte[2*(k/2) +: 2];
      bit_v = item_i.graphics_byte[k];
      if (multi) begin
        col = pal[pair];
        result_o.pixel_foreground[k] = pair[1];
      end else begin
        col = bit_v ? fgc : bgc;
        result_o.pixel_foreground[k] = bit_v;
      end
      result_o.pixel_colors[ColorW*k +: ColorW] = black ? ColorBlack : col;
    end
  end

endmodule

// ===== design/text_bitmap_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// text_bitmap_pixel_decoder
// Turns one graphics fetch into eight pixels (color + foreground flag).
// ----------------------------------------------------------------------------
// Usage
//   in_chan  : one beat per graphics fetch (graphics byte, character code,
//              color nibble, display-active flag)
//   out_chan : one beat per fetch, eight 4-bit colors (leftmost pixel in
//              the top nibble) and eight foreground flags (bit 7 leftmost)
//   APB port : display mode at 0x00, background colors 0..3 at 0x04..0x10;
//              write only while no fetch is in flight
// Path: a beat accepted into the input register is decoded and loaded into
//   the output register once that register is free, and its result is then
//   offered on out_chan.
// Throughput: one beat per cycle while out_chan.ready stays high; the decode
//   is combinational logic between the input and the output register.
// Reset: both register stages empty, mode = standard text, background colors
//   6, 1, 2, 3.
// Stall: a stalled output register holds its beat; the input register
//   fills, and in_chan.ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module text_bitmap_pixel_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tbpd_in_if.sink                    in_chan,
  tbpd_out_if.source                 out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tbpd_pkg::AddrW-1:0] paddr,
  input  logic [tbpd_pkg::DataW-1:0] pwdata,
  output logic [tbpd_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import tbpd_pkg::*;

  cfg_t    cfg;
  item_t   item_q, item_d;
  logic    in_vld_q, in_vld_d;
  result_t res_q, res_d;
  logic    out_vld_q, out_vld_d;
  logic    out_free, in_free;
  logic    in_take, advance;

  // configuration registers
  tbpd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stage handshakes
  assign out_free      = ~out_vld_q | out_chan.ready;
  assign advance       = in_vld_q & out_free;
  assign in_free       = ~in_vld_q | out_free;
  assign in_chan.ready = in_free;
  assign in_take       = in_chan.valid & in_free;

  // input register
  always_comb begin
    item_d   = item_q;
    in_vld_d = in_vld_q;
    if (in_free) begin
      in_vld_d = in_chan.valid;
      item_d.graphics_byte  = in_chan.graphics_byte;
      item_d.character_code = in_chan.character_code;
      item_d.cell_color     = in_chan.cell_color;
      item_d.display_active = in_chan.display_active;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
  end

  // pixel decode
  tbpd_decode u_decode (
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  // output register
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_free) begin
      out_vld_d = in_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_chan.valid            = out_vld_q;
  assign out_chan.pixel_colors     = res_q.pixel_colors;
  assign out_chan.pixel_foreground = res_q.pixel_foreground;

  // a fetch waiting in the input register stays while the output is blocked
  a_hold_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_free) |=> in_vld_q)
    else $error("input register lost a beat while output stalled");

  // input backpressure only when both stages are full
  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_chan.ready |-> (in_vld_q && out_vld_q))
    else $error("input stalled with a free stage");

  // invalid modes drive black on every pixel
  a_black_modes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cfg.display_mode[ModeEcmBit]
      && (cfg.display_mode[ModeBmmBit] || cfg.display_mode[ModeMcmBit]))
    |=> (res_q.pixel_colors == '0))
    else $error("invalid mode produced a non-black pixel");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text/bitmap pixel decoder. Fetch beats go in
// over the valid/ready channel, the registers are set over the APB port
// between phases, and every pixel beat is compared against a local decode
// of the same fetch under the current register settings.
// ----------------------------------------------------------------------------
module tb;
  import tbpd_pkg::*;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_e;

  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned PhaseItems  = 140;
  localparam int unsigned NumPhases   = 12;
  localparam int unsigned MaxReported = 10;
  localparam logic [RegIdxW-1:0] UnmappedReg = 3'd5;

  logic clk_i;
  logic rst_ni;

  // configuration port
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  tbpd_in_if  in_chan ();
  tbpd_out_if out_chan ();

  // register contents as the bench believes them to be
  cfg_t        shadow_cfg;
  result_t     pending_pixels[$];
  result_t     want_pixels;
  int unsigned pixel_errors;

  // receiver behavior, set by the tests
  rx_mode_e    rx_mode;
  logic [15:0] rx_pattern;
  int unsigned hold_seq;

  text_bitmap_pixel_decoder i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // eight pixels of one fetch under the given register settings
  function automatic result_t decode_pixels(input item_t f, input cfg_t c);
    logic [CodeW-1:0]  code;
    logic [ColorW-1:0] nib;
    logic              ecm;
    logic              bmm;
    logic              mcm;
    logic              multi;
    logic              blank;
    logic [ColorW-1:0] palette [4];
    logic [ColorW-1:0] bg_pick;
    logic [ColorW-1:0] fg_pick;
    logic [ColorW-1:0] pix;
    logic [1:0]        pair;
    logic              is_fg;
    result_t           r;
    code  = f.display_active ? f.character_code : '0;
    nib   = f.display_active ? f.cell_color : '0;
    ecm   = c.display_mode[ModeEcmBit];
    bmm   = c.display_mode[ModeBmmBit];
    mcm   = c.display_mode[ModeMcmBit];
    multi = mcm && (bmm || nib[3]);
    blank = ecm && (bmm || mcm);
    if (bmm) begin
      bg_pick    = code[3:0];
      fg_pick    = code[7:4];
      palette[0] = c.bg_color0;
      palette[1] = code[7:4];
      palette[2] = code[3:0];
      palette[3] = nib;
    end else begin
      if (!ecm) begin
        bg_pick = c.bg_color0;
      end else begin
        case (code[7:6])
          2'd0:    bg_pick = c.bg_color0;
          2'd1:    bg_pick = c.bg_color1;
          2'd2:    bg_pick = c.bg_color2;
          default: bg_pick = c.bg_color3;
        endcase
      end
      fg_pick    = mcm ? {1'b0, nib[2:0]} : nib;
      palette[0] = c.bg_color0;
      palette[1] = c.bg_color1;
      palette[2] = c.bg_color2;
      palette[3] = {1'b0, nib[2:0]};
    end
    r = '0;
    for (int p = 0; p < NumPix; p++) begin
      if (multi) begin
        // two bits per pixel pair, leftmost pair in the top bits
        pair  = f.graphics_byte[7 - 2 * (p / 2) -: 2];
        pix   = palette[pair];
        is_fg = pair[1];
      end else begin
        is_fg = f.graphics_byte[7 - p];
        pix   = is_fg ? fg_pick : bg_pick;
      end
      if (blank) pix = ColorBlack;
      r.pixel_colors[PixW - 1 - ColorW * p -: ColorW] = pix;
      r.pixel_foreground[NumPix - 1 - p] = is_fg;
    end
    return r;
  endfunction

  function automatic item_t random_fetch();
    item_t f;
    f.graphics_byte  = GfxW'($urandom);
    f.character_code = CodeW'($urandom);
    f.cell_color     = ColorW'($urandom);
    f.display_active = ($urandom_range(0, 3) != 0);
    return f;
  endfunction

  // one fetch beat; the expected pixels are queued at acceptance
  task automatic send_fetch(input item_t f);
    in_chan.valid          <= 1'b1;
    in_chan.graphics_byte  <= f.graphics_byte;
    in_chan.character_code <= f.character_code;
    in_chan.cell_color     <= f.cell_color;
    in_chan.display_active <= f.display_active;
    do @(posedge clk_i); while (!in_chan.ready);
    pending_pixels.push_back(decode_pixels(f, shadow_cfg));
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles > 0) begin
      in_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // stop offering and let every outstanding pixel beat come back
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DISPLAY_MODE: shadow_cfg.display_mode = value[ModeW-1:0];
      REG_BG_COLOR0:    shadow_cfg.bg_color0 = value[ColorW-1:0];
      REG_BG_COLOR1:    shadow_cfg.bg_color1 = value[ColorW-1:0];
      REG_BG_COLOR2:    shadow_cfg.bg_color2 = value[ColorW-1:0];
      REG_BG_COLOR3:    shadow_cfg.bg_color3 = value[ColorW-1:0];
      default: ;
    endcase
  endtask

  // all five registers; upper data bits carry junk now and then
  task automatic set_config(input logic [ModeW-1:0] mode, input logic [ColorW-1:0] b0,
                            input logic [ColorW-1:0] b1, input logic [ColorW-1:0] b2,
                            input logic [ColorW-1:0] b3);
    logic [DataW-1:0] junk;
    wait_drained();
    junk = ($urandom_range(0, 1) != 0) ? DataW'($urandom) : '0;
    write_reg(REG_DISPLAY_MODE, {junk[DataW-1:ModeW], mode});
    write_reg(REG_BG_COLOR0, {junk[DataW-1:ColorW], b0});
    write_reg(REG_BG_COLOR1, {junk[DataW-1:ColorW], b1});
    write_reg(REG_BG_COLOR2, {junk[DataW-1:ColorW], b2});
    write_reg(REG_BG_COLOR3, {junk[DataW-1:ColorW], b3});
  endtask

  // random fetches in bursts of random length with random gaps
  task automatic send_random_bursts(input int unsigned count);
    int unsigned left;
    int unsigned burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_fetch(random_fetch());
      left -= burst;
      pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // decode with the register values left by reset
  task automatic test_reset_values();
    rx_mode = RX_ALWAYS;
    send_fetch('{graphics_byte: 8'hA5, character_code: 8'hFF, cell_color: 4'hF,
                 display_active: 1'b1});
    send_fetch('{graphics_byte: 8'h5A, character_code: 8'h00, cell_color: 4'h9,
                 display_active: 1'b1});
  endtask

  // every mode, the invalid ones included, with fixed corner fetches
  task automatic test_modes();
    item_t f;
    rx_mode = RX_RANDOM;
    for (int m = 0; m < 8; m++) begin
      set_config(ModeW'(m), 4'hF, 4'h0, 4'h9, 4'h6);
      // all four pairs, ext background 3, color bit 3 set
      f = '{graphics_byte: 8'hE4, character_code: 8'hC3, cell_color: 4'hF,
            display_active: 1'b1};
      send_fetch(f);
      // color bit 3 clear, ext background 1
      f = '{graphics_byte: 8'h1B, character_code: 8'h5A, cell_color: 4'h7,
            display_active: 1'b1};
      send_fetch(f);
      // idle fetch: code and color must read as zero
      f = '{graphics_byte: (m % 2 == 0) ? 8'hFF : 8'h00, character_code: 8'h81,
            cell_color: 4'h8, display_active: 1'b0};
      send_fetch(f);
    end
  endtask

  // a write outside the register map changes nothing
  task automatic test_unmapped_write();
    set_config(3'd4, 4'h3, 4'hC, 4'h5, 4'hA);
    write_reg(UnmappedReg, 32'hFFFF_FFFF);
    rx_mode = RX_ALWAYS;
    send_random_bursts(20);
  endtask

  // two long receiver holds with the sender still offering, each followed by a full drain
  task automatic test_backpressure();
    rx_mode = RX_ALWAYS;
    set_config(3'd3, 4'h1, 4'h2, 4'h4, 4'h8);
    hold_seq++;
    repeat (40) send_fetch(random_fetch());
    wait_drained();
    rx_mode = RX_RANDOM;
    hold_seq++;
    repeat (20) send_fetch(random_fetch());
    wait_drained();
  endtask

  // phases of random fetches, a new setting and receiver behavior each
  task automatic test_random_phases();
    logic [ColorW-1:0] b [4];
    for (int ph = 0; ph < NumPhases; ph++) begin
      for (int k = 0; k < 4; k++) begin
        b[k] = (ph == 0) ? 4'h0 : (ph == 1) ? 4'hF : ColorW'($urandom);
      end
      set_config((ph == 1) ? 3'd7 : ModeW'(ph % 8), b[0], b[1], b[2], b[3]);
      rx_mode    = rx_mode_e'(ph % 3);
      rx_pattern = 16'($urandom) | 16'h0101;
      send_random_bursts(PhaseItems);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_chan.valid          = 1'b0;
    in_chan.graphics_byte  = '0;
    in_chan.character_code = '0;
    in_chan.cell_color     = '0;
    in_chan.display_active = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rx_mode    = RX_ALWAYS;
    rx_pattern = 16'hFFFF;
    hold_seq   = 0;
    pixel_errors = 0;
    shadow_cfg = '{display_mode: ModeRst, bg_color0: Bg0Rst, bg_color1: Bg1Rst,
                   bg_color2: Bg2Rst, bg_color3: Bg3Rst};
    @(posedge rst_ni);
    @(posedge clk_i);

    test_reset_values();
    test_modes();
    test_unmapped_write();
    test_backpressure();
    test_random_phases();

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (pixel_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver: long holds on request, otherwise the selected stall pattern
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    logic [3:0]  beat_phase;
    out_chan.ready = 1'b0;
    hold_left  = 0;
    hold_seen  = 0;
    beat_phase = '0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_chan.ready <= 1'b1;
          RX_RANDOM: out_chan.ready <= ($urandom_range(0, 3) != 0);
          default: begin
            out_chan.ready <= rx_pattern[beat_phase];
            beat_phase++;
          end
        endcase
      end
    end
  end

  task automatic report_mismatch(input string field, input logic [PixW-1:0] want,
                                 input logic [PixW-1:0] got);
    pixel_errors++;
    if (pixel_errors <= MaxReported) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
    end
  endtask

  // pixel beat checker
  always @(posedge clk_i) begin
    if (rst_ni && out_chan.valid && out_chan.ready) begin
      if (pending_pixels.size() == 0) begin
        pixel_errors++;
        if (pixel_errors <= MaxReported) begin
          $display("%0t: pixel beat with nothing expected, colors %h", $realtime,
                   out_chan.pixel_colors);
        end
      end else begin
        want_pixels = pending_pixels.pop_front();
        if (out_chan.pixel_colors !== want_pixels.pixel_colors) begin
          report_mismatch("pixel_colors", want_pixels.pixel_colors, out_chan.pixel_colors);
        end
        if (out_chan.pixel_foreground !== want_pixels.pixel_foreground) begin
          report_mismatch("pixel_foreground", PixW'(want_pixels.pixel_foreground),
                          PixW'(out_chan.pixel_foreground));
        end
      end
    end
  end

endmodule
